>>> src/fdtd_pkg.sv
package fdtd_pkg;

    localparam int COEF_SLOTS = 6;
    localparam int FIELD_W    = 32;
    localparam int CURL_W     = 34;
    localparam int ACC_W      = 80;

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CELL = 1'b1;

    typedef struct packed {
        logic [FIELD_W-1:0] ce;
        logic [FIELD_W-1:0] ch;
    } coef_pair_t;

    function automatic logic [FIELD_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] r;
        logic signed [ACC_W-1:0] q;
        begin
            r = acc + (ACC_W'(1) <<< 29);
            q = r >>> 30;
            if (q > ACC_W'(32'sh7fffffff))
                round_sat = 32'h7fffffff;
            else if (q < -(ACC_W'(64'sh80000000)))
                round_sat = 32'h80000000;
            else
                round_sat = q[FIELD_W-1:0];
        end
    endfunction

endpackage

>>> src/fdtd_if.sv
interface fdtd_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [6:0]  coef_addr;
    logic [31:0] coef_value;
    logic [31:0] e_x_old;
    logic [31:0] e_y_old;
    logic [31:0] e_z_old;
    logic [31:0] h_x_here;
    logic [31:0] h_y_here;
    logic [31:0] h_z_here;
    logic [3:0]  material_id;
    modport source (output valid, command, coef_addr, coef_value, e_x_old, e_y_old,
                    e_z_old, h_x_here, h_y_here, h_z_here, material_id, input ready);
    modport sink   (input valid, command, coef_addr, coef_value, e_x_old, e_y_old,
                    e_z_old, h_x_here, h_y_here, h_z_here, material_id, output ready);
endinterface

interface fdtd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] e_x_new;
    logic [31:0] e_y_new;
    logic [31:0] e_z_new;
    logic        grid_end;
    modport source (output valid, e_x_new, e_y_new, e_z_new, grid_end, input ready);
    modport sink   (input valid, e_x_new, e_y_new, e_z_new, grid_end, output ready);
endinterface

>>> src/fdtd_lane.sv
module fdtd_lane
(
    input  logic                 clk,
    input  logic                 en,
    input  logic                 upd,
    input  logic [31:0]          e_old,
    input  logic [31:0]          ce,
    input  logic [31:0]          ch,
    input  logic signed [33:0]   curl,
    output logic [31:0]          e_new
);
    logic signed [63:0] pe_reg;
    logic signed [65:0] ph_reg;
    logic               upd_reg;
    logic [31:0]        e_reg;
    logic signed [fdtd_pkg::ACC_W-1:0] sum;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pe_reg  <= $signed(ce) * $signed(e_old);
            ph_reg  <= $signed(ch) * curl;
            upd_reg <= upd;
            e_reg   <= e_old;
        end
    end

    assign sum = fdtd_pkg::ACC_W'(pe_reg) + fdtd_pkg::ACC_W'(ph_reg);
    assign e_new = upd_reg ? fdtd_pkg::round_sat(sum) : e_reg;
endmodule

>>> src/fdtd_e_field_stencil_update.sv
// channel | dir | handshake    | word
// in_c    | in  | valid/ready  | command, coef, E old, H here, material
// out_c   | out | valid/ready  | E new, grid_end
// apb     | in  | psel/penable | grid sizes
// One cell per cycle while the output register is empty or taken; an accepted cell has its
// buffer and table read into stage 1, then curl and multiply into the lane registers; add,
// round and saturate feed the output. A coefficient load gives no word.
// Reset clears positions and the z-1 register and sets sizes to 64; buffers need no clearing.
// The pipeline advances when the output register is empty or taken.
module fdtd_e_field_stencil_update #(
    parameter int MAX_X = 1024,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64,
    parameter int NUM_MATERIALS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    fdtd_in_if.sink     in_c,
    fdtd_out_if.source  out_c,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int XW = $clog2(MAX_X);
    localparam int YW = $clog2(MAX_Y);
    localparam int ZW = $clog2(MAX_Z);
    localparam int PW = $clog2(MAX_Y*MAX_Z);
    localparam int TD = NUM_MATERIALS * fdtd_pkg::COEF_SLOTS;
    localparam int MW = (NUM_MATERIALS > 1) ? $clog2(NUM_MATERIALS) : 1;

    logic [10:0] gsx_reg;
    logic [6:0]  gsy_reg, gsz_reg;
    logic [XW-1:0] px_reg;
    logic [YW-1:0] py_reg;
    logic [ZW-1:0] pz_reg;
    logic [63:0] prev_reg;
    logic        cfg_wr;

    logic [31:0] ctab_mem [fdtd_pkg::COEF_SLOTS][NUM_MATERIALS];
    logic [63:0] plane_mem [MAX_Y*MAX_Z];
    logic [63:0] line_mem [MAX_Z];

    logic        v1_reg, v2_reg;
    logic        adv;
    logic [16:0] sx, sy, sz;
    logic [16:0] xe, ye, ze;
    logic        cell_in, load_in;
    logic [MW-1:0] mat;
    logic [PW-1:0] pidx;
    logic [13:0] ld_prod;
    logic [6:0]  ld_mat;
    logic [6:0]  ld_rem;
    logic [2:0]  ld_slot;

    // stage 1 registers, then the stage 2 grid-end flag, lane outputs and curls
    logic [31:0] ex1_reg, ey1_reg, ez1_reg, hx1_reg, hy1_reg, hz1_reg;
    logic [31:0] pc_hx1_reg, pc_hy1_reg;
    logic [63:0] pl1_reg, ln1_reg;
    logic [31:0] c1_reg [6];
    logic [2:0]  upd1_reg;
    logic        last1_reg;
    logic        v2_last_reg;
    logic [31:0] nx, ny, nz;
    logic signed [33:0] cx, cy, cz;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb
    begin
        case (paddr[3:2])
            fdtd_pkg::REG_SIZE_X: prdata = {21'd0, gsx_reg};
            fdtd_pkg::REG_SIZE_Y: prdata = {25'd0, gsy_reg};
            fdtd_pkg::REG_SIZE_Z: prdata = {25'd0, gsz_reg};
            default:              prdata = '0;
        endcase
    end

    function automatic logic [16:0] clampv(input logic [10:0] v, input int hi);
        begin
            if (v < 11'd2) clampv = 17'd2;
            else if (32'(v) > hi) clampv = 17'(hi);
            else clampv = 17'(v);
        end
    endfunction

    assign sx = clampv(gsx_reg, MAX_X);
    assign sy = clampv({4'd0, gsy_reg}, MAX_Y);
    assign sz = clampv({4'd0, gsz_reg}, MAX_Z);
    assign xe = 17'(px_reg);
    assign ye = 17'(py_reg);
    assign ze = 17'(pz_reg);
    assign pidx = PW'(32'(py_reg) * MAX_Z + 32'(pz_reg));

    // split the load address into material and slot: floor(a/6) = (a*43) >> 8 for a < 128
    assign ld_prod = 14'(in_c.coef_addr) * 14'd43;
    assign ld_mat  = {1'b0, ld_prod[13:8]};
    assign ld_rem  = in_c.coef_addr - 7'(ld_mat * 7'd6);
    assign ld_slot = ld_rem[2:0];

    assign adv = !v2_reg || out_c.ready;
    assign in_c.ready = adv;
    assign cell_in = in_c.valid && adv && (in_c.command == fdtd_pkg::CMD_CELL);
    assign load_in = in_c.valid && adv && (in_c.command == fdtd_pkg::CMD_LOAD);
    assign mat = (32'(in_c.material_id) >= NUM_MATERIALS) ? MW'(NUM_MATERIALS - 1)
                                                          : MW'(in_c.material_id);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gsx_reg  <= 11'd64;
            gsy_reg  <= 7'd64;
            gsz_reg  <= 7'd64;
            px_reg   <= '0;
            py_reg   <= '0;
            pz_reg   <= '0;
            prev_reg <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr && paddr[3:2] <= fdtd_pkg::REG_SIZE_Z)
            begin
                case (paddr[3:2])
                    fdtd_pkg::REG_SIZE_X: gsx_reg <= pwdata[10:0];
                    fdtd_pkg::REG_SIZE_Y: gsy_reg <= pwdata[6:0];
                    default:              gsz_reg <= pwdata[6:0];
                endcase
                px_reg <= '0;
                py_reg <= '0;
                pz_reg <= '0;
            end
            else if (cell_in)
            begin
                prev_reg <= {in_c.h_y_here, in_c.h_x_here};
                if (ze + 17'd1 < sz)
                    pz_reg <= pz_reg + 1'b1;
                else
                begin
                    pz_reg <= '0;
                    if (ye + 17'd1 < sy)
                        py_reg <= py_reg + 1'b1;
                    else
                    begin
                        py_reg <= '0;
                        px_reg <= (xe + 17'd1 < sx) ? px_reg + 1'b1 : '0;
                    end
                end
            end
            if (adv)
            begin
                v1_reg <= cell_in;
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in && 32'(in_c.coef_addr) < TD)
            ctab_mem[ld_slot][MW'(ld_mat)] <= in_c.coef_value;
        if (cell_in)
        begin
            plane_mem[pidx] <= {in_c.h_z_here, in_c.h_y_here};
            line_mem[pz_reg] <= {in_c.h_z_here, in_c.h_x_here};
        end
        if (adv)
        begin
            pl1_reg    <= plane_mem[pidx];
            ln1_reg    <= line_mem[pz_reg];
            for (int i = 0; i < 6; i++)
                c1_reg[i] <= ctab_mem[i][mat];
            ex1_reg    <= in_c.e_x_old;
            ey1_reg    <= in_c.e_y_old;
            ez1_reg    <= in_c.e_z_old;
            hx1_reg    <= in_c.h_x_here;
            hy1_reg    <= in_c.h_y_here;
            hz1_reg    <= in_c.h_z_here;
            pc_hx1_reg <= prev_reg[31:0];
            pc_hy1_reg <= prev_reg[63:32];
            upd1_reg[0] <= (xe < sx - 1) && (ye >= 1) && (ye < sy - 1)
                           && (ze >= 1) && (ze < sz - 1);
            upd1_reg[1] <= (xe >= 1) && (xe < sx - 1) && (ye < sy - 1)
                           && (ze >= 1) && (ze < sz - 1);
            upd1_reg[2] <= (xe >= 1) && (xe < sx - 1) && (ye >= 1)
                           && (ye < sy - 1) && (ze < sz - 1);
            last1_reg  <= (xe == sx - 1) && (ye == sy - 1) && (ze == sz - 1);
            v2_last_reg <= last1_reg;
        end
    end

    assign cx = 34'(signed'(hz1_reg)) - 34'(signed'(ln1_reg[63:32]))
              - 34'(signed'(hy1_reg)) + 34'(signed'(pc_hy1_reg));
    assign cy = 34'(signed'(hx1_reg)) - 34'(signed'(pc_hx1_reg))
              - 34'(signed'(hz1_reg)) + 34'(signed'(pl1_reg[63:32]));
    assign cz = 34'(signed'(hy1_reg)) - 34'(signed'(pl1_reg[31:0]))
              - 34'(signed'(hx1_reg)) + 34'(signed'(ln1_reg[31:0]));

    fdtd_lane u_lx (.clk(clk), .en(adv), .upd(upd1_reg[0]), .e_old(ex1_reg),
                    .ce(c1_reg[0]), .ch(c1_reg[1]), .curl(cx), .e_new(nx));
    fdtd_lane u_ly (.clk(clk), .en(adv), .upd(upd1_reg[1]), .e_old(ey1_reg),
                    .ce(c1_reg[2]), .ch(c1_reg[3]), .curl(cy), .e_new(ny));
    fdtd_lane u_lz (.clk(clk), .en(adv), .upd(upd1_reg[2]), .e_old(ez1_reg),
                    .ce(c1_reg[4]), .ch(c1_reg[5]), .curl(cz), .e_new(nz));

    assign out_c.valid    = v2_reg;
    assign out_c.e_x_new  = nx;
    assign out_c.e_y_new  = ny;
    assign out_c.e_z_new  = nz;
    assign out_c.grid_end = v2_last_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_c.valid && !out_c.ready |=> out_c.valid && $stable(out_c.e_x_new))
        else $error("result dropped under stall");
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        17'(pz_reg) < sz || 17'(pz_reg) == 17'd0 || $past(cfg_wr))
        else $error("z position out of range");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_in |=> !v1_reg)
        else $error("load produced a word");
endmodule

>>> tb/fdtd_checker.sv
`timescale 1ns / 100ps

module fdtd_checker
(
    input  logic        clk,
    input  logic        rst_n,
    fdtd_in_if          in_c,
    fdtd_out_if         out_c,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending,
    output int          checked
);

    localparam int MAX_X = 1024;
    localparam int MAX_Y = 64;
    localparam int MAX_Z = 64;
    localparam int TABLE_DEPTH = 16 * fdtd_pkg::COEF_SLOTS;

    typedef struct packed {
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] ez;
        logic        last;
    } e_word_t;

    e_word_t     e_expected [$];
    logic [31:0] coef_mem [TABLE_DEPTH];
    logic [63:0] plane_h [MAX_Y * MAX_Z];
    logic [63:0] line_h [MAX_Z];
    logic [63:0] prev_h;
    int          px, py, pz;
    logic [10:0] size_x;
    logic [6:0]  size_y, size_z;
    int          reported;

    function automatic int clamp_size(int v, int hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [31:0] e_update(logic signed [31:0] e, logic signed [31:0] ce,
                                            logic signed [31:0] ch, longint curl);
        logic signed [95:0] a, b, c, d, acc;
        a = e;
        b = ce;
        c = ch;
        d = curl;
        acc = (a * b + c * d + (96'sd1 <<< 29)) >>> 30;
        if (acc > 96'sd2147483647)
            return 32'h7fffffff;
        if (acc < -96'sd2147483648)
            return 32'h80000000;
        return acc[31:0];
    endfunction

    function automatic longint sx32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    task automatic predict_cell();
        int          sx, sy, sz, x, y, z, base, pidx;
        longint      hx, hy, hz;
        e_word_t     w;
        sx = clamp_size(size_x, MAX_X);
        sy = clamp_size(size_y, MAX_Y);
        sz = clamp_size(size_z, MAX_Z);
        if (px >= sx || py >= sy || pz >= sz)
        begin
            px = 0;
            py = 0;
            pz = 0;
        end
        x = px;
        y = py;
        z = pz;
        hx = sx32(in_c.h_x_here);
        hy = sx32(in_c.h_y_here);
        hz = sx32(in_c.h_z_here);
        base = in_c.material_id * fdtd_pkg::COEF_SLOTS;
        pidx = y * MAX_Z + z;
        w.ex = in_c.e_x_old;
        w.ey = in_c.e_y_old;
        w.ez = in_c.e_z_old;
        if (x < sx - 1 && y >= 1 && y < sy - 1 && z >= 1 && z < sz - 1)
            w.ex = e_update(in_c.e_x_old, coef_mem[base], coef_mem[base + 1],
                            hz - sx32(line_h[z][63:32]) - hy + sx32(prev_h[63:32]));
        if (x >= 1 && x < sx - 1 && y < sy - 1 && z >= 1 && z < sz - 1)
            w.ey = e_update(in_c.e_y_old, coef_mem[base + 2], coef_mem[base + 3],
                            hx - sx32(prev_h[31:0]) - hz + sx32(plane_h[pidx][63:32]));
        if (x >= 1 && x < sx - 1 && y >= 1 && y < sy - 1 && z < sz - 1)
            w.ez = e_update(in_c.e_z_old, coef_mem[base + 4], coef_mem[base + 5],
                            hy - sx32(plane_h[pidx][31:0]) - hx + sx32(line_h[z][31:0]));
        plane_h[pidx] = {in_c.h_z_here, in_c.h_y_here};
        line_h[z] = {in_c.h_z_here, in_c.h_x_here};
        prev_h = {in_c.h_y_here, in_c.h_x_here};
        w.last = (x == sx - 1 && y == sy - 1 && z == sz - 1);
        if (z + 1 < sz)
            pz = z + 1;
        else
        begin
            pz = 0;
            if (y + 1 < sy)
                py = y + 1;
            else
            begin
                py = 0;
                px = (x + 1 < sx) ? x + 1 : 0;
            end
        end
        e_expected.push_back(w);
    endtask

    task automatic flag(string what);
        fail_count++;
        if (reported < 10)
        begin
            reported++;
            $display("%0t mismatch: %s", $realtime, what);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        e_word_t got, want;
        if (!rst_n)
        begin
            e_expected.delete();
            prev_h = '0;
            px = 0;
            py = 0;
            pz = 0;
            size_x = 11'd64;
            size_y = 7'd64;
            size_z = 7'd64;
            fail_count = 0;
            checked <= 0;
            reported = 0;
        end
        else
        begin
            if (out_c.valid && out_c.ready)
            begin
                got = {out_c.e_x_new, out_c.e_y_new, out_c.e_z_new, out_c.grid_end};
                if (e_expected.size() == 0)
                    flag($sformatf("unexpected word %h", got));
                else
                begin
                    want = e_expected.pop_front();
                    checked <= checked + 1;
                    if (got.ex !== want.ex)
                        flag($sformatf("e_x_new exp %h got %h", want.ex, got.ex));
                    if (got.ey !== want.ey)
                        flag($sformatf("e_y_new exp %h got %h", want.ey, got.ey));
                    if (got.ez !== want.ez)
                        flag($sformatf("e_z_new exp %h got %h", want.ez, got.ez));
                    if (got.last !== want.last)
                        flag($sformatf("grid_end exp %b got %b", want.last, got.last));
                end
            end
            if (in_c.valid && in_c.ready)
            begin
                if (in_c.command == fdtd_pkg::CMD_LOAD)
                begin
                    if (in_c.coef_addr < TABLE_DEPTH)
                        coef_mem[in_c.coef_addr] = in_c.coef_value;
                end
                else
                    predict_cell();
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    fdtd_pkg::REG_SIZE_X: size_x = pwdata[10:0];
                    fdtd_pkg::REG_SIZE_Y: size_y = pwdata[6:0];
                    fdtd_pkg::REG_SIZE_Z: size_z = pwdata[6:0];
                    default: ;
                endcase
                if (paddr[3:2] <= fdtd_pkg::REG_SIZE_Z)
                begin
                    px = 0;
                    py = 0;
                    pz = 0;
                end
            end
        end
        pending <= e_expected.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int GRID_X [9] = '{3, 2, 0, 5, 1024, 2047, 4, 7, 1};
    localparam int GRID_Y [9] = '{3, 2, 1, 4, 64, 127, 5, 3, 64};
    localparam int GRID_Z [9] = '{3, 2, 1, 6, 64, 127, 3, 8, 2};
    localparam logic [31:0] COEF_ENDS [4] = '{32'h80000000, 32'h7fffffff, 32'h0,
                                              32'h40000000};

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          checked;
    int          cells_sent;
    int          loads_sent;
    int          phases_run;
    bit          calm;
    bit          hold_request;
    int          hold_left;
    int          stall_left;

    fdtd_in_if  in_c ();
    fdtd_out_if out_c ();

    fdtd_e_field_stencil_update uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_c    (in_c),
        .out_c   (out_c),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fdtd_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_c       (in_c),
        .out_c      (out_c),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic nxt;
        if (!rst_n)
        begin
            out_c.ready <= 1'b0;
            hold_left = 0;
            stall_left = 0;
        end
        else
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 300;
            end
            if (out_c.valid && out_c.ready)
                stall_left = calm ? 0 : $urandom_range(0, 11);
            if (hold_left > 0)
            begin
                hold_left--;
                nxt = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                nxt = 1'b0;
            end
            else
                nxt = 1'b1;
            out_c.ready <= nxt;
        end
    end

    function automatic logic [31:0] pick_field();
        case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h0;
            3: return $urandom_range(0, 255) - 128;
            4: return {{14{1'b0}}, 18'($urandom)} - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(logic cmd, logic [6:0] addr, logic [31:0] cval,
                             logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                             logic [31:0] hx, logic [31:0] hy, logic [31:0] hz,
                             logic [3:0] mat);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_c.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_c.valid       <= 1'b1;
        in_c.command     <= cmd;
        in_c.coef_addr   <= addr;
        in_c.coef_value  <= cval;
        in_c.e_x_old     <= ex;
        in_c.e_y_old     <= ey;
        in_c.e_z_old     <= ez;
        in_c.h_x_here    <= hx;
        in_c.h_y_here    <= hy;
        in_c.h_z_here    <= hz;
        in_c.material_id <= mat;
        @(posedge clk);
        while (!in_c.ready)
            @(posedge clk);
        if (cmd == fdtd_pkg::CMD_CELL)
            cells_sent++;
        else
            loads_sent++;
    endtask

    task automatic send_cell();
        send_word(fdtd_pkg::CMD_CELL, 7'($urandom), $urandom, pick_field(), pick_field(),
                  pick_field(), pick_field(), pick_field(), pick_field(), 4'($urandom));
    endtask

    task automatic send_load(logic [6:0] addr, logic [31:0] cval);
        send_word(fdtd_pkg::CMD_LOAD, addr, cval, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, 4'($urandom));
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_grid(int sx, int sy, int sz);
        in_c.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);
        apb_write(fdtd_pkg::REG_SIZE_X, 32'(sx));
        apb_write(fdtd_pkg::REG_SIZE_Y, 32'(sy));
        apb_write(fdtd_pkg::REG_SIZE_Z, 32'(sz));
        phases_run++;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_c.valid   = 1'b0;
        in_c.command = fdtd_pkg::CMD_LOAD;
        in_c.coef_addr   = '0;
        in_c.coef_value  = '0;
        in_c.e_x_old     = '0;
        in_c.e_y_old     = '0;
        in_c.e_z_old     = '0;
        in_c.h_x_here    = '0;
        in_c.h_y_here    = '0;
        in_c.h_z_here    = '0;
        in_c.material_id = '0;
        calm         = 1'b1;
        hold_request = 1'b0;
        cells_sent   = 0;
        loads_sent   = 0;
        phases_run   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int a = 0; a < 96; a++)
            send_load(7'(a), (a < 24) ? COEF_ENDS[a % 4] : $urandom);
        send_load(7'd96, 32'h7fffffff);
        send_load(7'd127, 32'h80000000);
        set_grid(3, 3, 3);
        for (int i = 0; i < 27; i++)
        begin
            if (i == 13)
                send_word(fdtd_pkg::CMD_CELL, 7'd0, 32'd0, 32'h7fffffff, 32'h80000000,
                          32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 4'd1);
            else if (i < 4)
                send_word(fdtd_pkg::CMD_CELL, 7'd0, 32'd0, {32{i[0]}} ^ 32'h80000000,
                          {32{i[1]}} ^ 32'h7fffffff, 32'h0, 32'h7fffffff,
                          32'h80000000, 32'h7fffffff, i[3:0]);
            else
                send_cell();
        end

        for (int p = 0; p < 9; p++)
        begin
            calm = p[0];
            set_grid(GRID_X[p], GRID_Y[p], GRID_Z[p]);
            if (p == 2)
                hold_request = 1'b1;
            for (int i = 0; i < 100; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_load(7'($urandom_range(0, 127)), pick_field());
                else
                    send_cell();
            end
        end

        in_c.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (10) @(posedge clk);
        $display("Sent %0d cells and %0d coefficient loads over %0d grid settings;",
                 cells_sent, loads_sent, phases_run);
        $display("compared %0d result words, %0d failures.", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
src/fdtd_pkg.sv
src/fdtd_if.sv
src/fdtd_lane.sv
src/fdtd_e_field_stencil_update.sv
tb/fdtd_checker.sv
tb/testbench.sv
